>>> rtl/ccfr_pkg.sv
`timescale 1ns / 1ps

package ccfr_pkg;

	// frame layout and protocol constants
	localparam int unsigned HdrBytes = 16;
	localparam logic [31:0] CrcPoly  = 32'hEDB8_8320;
	localparam logic [31:0] CrcInit  = 32'hFFFF_FFFF;
	localparam logic [7:0]  ProtoVersion = 8'h01;
	localparam logic [7:0]  TypeHello    = 8'h01;
	localparam logic [7:0]  TypeImage    = 8'h02;

	// register indexes on the config port
	localparam logic [0:0] RegEngineReady = 1'd0;
	localparam logic [0:0] RegImageLength = 1'd1;

	// verdict codes
	typedef enum logic [1:0] {
		VERDICT_ERROR = 2'd0,
		VERDICT_HELLO = 2'd1,
		VERDICT_IMAGE = 2'd2
	} verdict_t;

	// error codes
	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_MAGIC    = 3'd1,
		ERR_VERSION  = 3'd2,
		ERR_MESSAGE  = 3'd3,
		ERR_LENGTH   = 3'd4,
		ERR_CRC      = 3'd5,
		ERR_NOTREADY = 3'd6,
		ERR_LINK     = 3'd7
	} err_code_t;

	// one result word from the frame controller
	typedef struct packed {
		logic      valid;
		verdict_t  verdict;
		err_code_t code;
	} ccfr_result_t;

	// expected magic bytes 'S','S','E','G'
	function automatic logic [7:0] sync_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = 8'h53;
			2'd1: b = 8'h53;
			2'd2: b = 8'h45;
			default: b = 8'h47;
		endcase
		return b;
	endfunction

	// reflected crc-32 over one byte, unrolled
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
		end
		return c;
	endfunction

	// replace one byte lane of a little-endian word
	function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] lane,
		input logic [7:0] b);
		logic [31:0] r;
		r = w;
		case (lane)
			2'd0: r[7:0]   = b;
			2'd1: r[15:8]  = b;
			2'd2: r[23:16] = b;
			default: r[31:24] = b;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/ccfr_frame_ctrl.sv
`timescale 1ns / 1ps

module ccfr_frame_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [7:0]            rx_byte,
	input  logic                  link_fault,
	input  logic                  engine_ready,
	input  logic [31:0]           image_length,
	output ccfr_pkg::ccfr_result_t res
);

	logic [3:0]  hdr_cnt_q;
	logic        magic_bad_q;
	logic [7:0]  version_q;
	logic [7:0]  msg_type_q;
	logic [15:0] status_q;
	logic [31:0] dlen_q;
	logic [31:0] dcrc_q;
	logic        in_payload_q;
	logic [31:0] left_q;
	logic [31:0] crc_q;

	logic [31:0] crc_upd;
	logic [31:0] left_dec;
	logic [31:0] dcrc_full;
	logic        magic_bad_eff;
	logic        hdr_last;
	logic        start_image;

	// per-word decode and frame checks
	always_comb begin
		crc_upd   = ccfr_pkg::crc_byte(crc_q, rx_byte);
		left_dec  = left_q - 32'd1;
		dcrc_full = ccfr_pkg::put_byte(dcrc_q, hdr_cnt_q[1:0], rx_byte);
		magic_bad_eff = ((hdr_cnt_q == 4'd0) ? 1'b0 : magic_bad_q) |
			((hdr_cnt_q < 4'd4) && (rx_byte != ccfr_pkg::sync_byte(hdr_cnt_q[1:0])));
		hdr_last    = (hdr_cnt_q == 4'(ccfr_pkg::HdrBytes - 1));
		start_image = 1'b0;
		res         = '0;
		if (en) begin
			if (link_fault) begin
				res = '{1'b1, ccfr_pkg::VERDICT_ERROR, ccfr_pkg::ERR_LINK};
			end else if (in_payload_q) begin
				if (left_dec == 32'd0) begin
					if (~crc_upd == dcrc_q) begin
						res = '{1'b1, ccfr_pkg::VERDICT_IMAGE, ccfr_pkg::ERR_NONE};
					end else begin
						res = '{1'b1, ccfr_pkg::VERDICT_ERROR, ccfr_pkg::ERR_CRC};
					end
				end
			end else if (hdr_last) begin
				if (magic_bad_q) begin
					res = '{1'b1, ccfr_pkg::VERDICT_ERROR, ccfr_pkg::ERR_MAGIC};
				end else if (version_q != ccfr_pkg::ProtoVersion) begin
					res = '{1'b1, ccfr_pkg::VERDICT_ERROR, ccfr_pkg::ERR_VERSION};
				end else if (status_q != 16'd0) begin
					res = '{1'b1, ccfr_pkg::VERDICT_ERROR, ccfr_pkg::ERR_MESSAGE};
				end else if (msg_type_q == ccfr_pkg::TypeHello) begin
					if (dlen_q != 32'd0) begin
						res = '{1'b1, ccfr_pkg::VERDICT_ERROR, ccfr_pkg::ERR_LENGTH};
					end else if (!engine_ready) begin
						res = '{1'b1, ccfr_pkg::VERDICT_ERROR, ccfr_pkg::ERR_NOTREADY};
					end else begin
						res = '{1'b1, ccfr_pkg::VERDICT_HELLO, ccfr_pkg::ERR_NONE};
					end
				end else if (msg_type_q == ccfr_pkg::TypeImage) begin
					if (!engine_ready) begin
						res = '{1'b1, ccfr_pkg::VERDICT_ERROR, ccfr_pkg::ERR_NOTREADY};
					end else if (dlen_q != image_length) begin
						res = '{1'b1, ccfr_pkg::VERDICT_ERROR, ccfr_pkg::ERR_LENGTH};
					end else if (dlen_q == 32'd0) begin
						// empty image: crc of no bytes is zero
						if (dcrc_full == 32'd0) begin
							res = '{1'b1, ccfr_pkg::VERDICT_IMAGE, ccfr_pkg::ERR_NONE};
						end else begin
							res = '{1'b1, ccfr_pkg::VERDICT_ERROR, ccfr_pkg::ERR_CRC};
						end
					end else begin
						start_image = 1'b1;
					end
				end else begin
					res = '{1'b1, ccfr_pkg::VERDICT_ERROR, ccfr_pkg::ERR_MESSAGE};
				end
			end
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q    <= '0;
			magic_bad_q  <= 1'b0;
			version_q    <= '0;
			msg_type_q   <= '0;
			status_q     <= '0;
			dlen_q       <= '0;
			dcrc_q       <= '0;
			in_payload_q <= 1'b0;
			left_q       <= '0;
			crc_q        <= ccfr_pkg::CrcInit;
		end else if (en) begin
			if (link_fault) begin
				hdr_cnt_q    <= '0;
				magic_bad_q  <= 1'b0;
				in_payload_q <= 1'b0;
				left_q       <= '0;
				crc_q        <= ccfr_pkg::CrcInit;
			end else if (in_payload_q) begin
				crc_q  <= crc_upd;
				left_q <= left_dec;
				if (left_dec == 32'd0) begin
					in_payload_q <= 1'b0;
				end
			end else begin
				magic_bad_q <= magic_bad_eff;
				// capture header fields by position
				case (hdr_cnt_q[3:2])
					2'd1: begin
						if (hdr_cnt_q[1:0] == 2'd0) begin
							version_q <= rx_byte;
						end else if (hdr_cnt_q[1:0] == 2'd1) begin
							msg_type_q <= rx_byte;
						end else if (hdr_cnt_q[1:0] == 2'd2) begin
							status_q[7:0] <= rx_byte;
						end else begin
							status_q[15:8] <= rx_byte;
						end
					end
					2'd2: dlen_q <= ccfr_pkg::put_byte(dlen_q, hdr_cnt_q[1:0], rx_byte);
					2'd3: dcrc_q <= dcrc_full;
					default: ;
				endcase
				if (hdr_last) begin
					hdr_cnt_q <= '0;
					if (start_image) begin
						crc_q        <= ccfr_pkg::CrcInit;
						left_q       <= dlen_q;
						in_payload_q <= 1'b1;
					end else if ((msg_type_q == ccfr_pkg::TypeImage) && (res.code != ccfr_pkg::ERR_NOTREADY)
						&& (dlen_q == image_length) && (magic_bad_q == 1'b0)
						&& (version_q == ccfr_pkg::ProtoVersion) && (status_q == 16'd0)) begin
						// empty image finished at header end
						crc_q  <= ccfr_pkg::CrcInit;
						left_q <= '0;
					end
				end else begin
					hdr_cnt_q <= hdr_cnt_q + 4'd1;
				end
			end
		end
	end

endmodule

>>> rtl/crc_checked_frame_receiver_top.sv
`timescale 1ns / 1ps
// a word is held in the input stage, and its result word, if any, in the result register
// throughput: one word per cycle if not stalled; byte-wide crc and header compare in one stage
// a stalled result holds in the output register while one further word waits in the input stage
// reset: arst_n clears all frame state, the pipeline and output valid asynchronously
// reset values: engine_ready 0, image_length 4096, crc all ones, header phase
module crc_checked_frame_receiver_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	input  logic        s_axis_tuser,  // [0] link_fault
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [1:0] verdict, [4:2] error_code, [7:5] zero
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	logic        engine_ready_q;
	logic [31:0] image_length_q;
	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        fault_s1;
	logic        out_valid_q;
	logic [1:0]  verdict_q;
	logic [2:0]  code_q;
	logic        advance;
	ccfr_pkg::ccfr_result_t res;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !v_s1 || advance;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			engine_ready_q <= 1'b0;
			image_length_q <= 32'd4096;
		end else if (cfg_we) begin
			case (cfg_index)
				ccfr_pkg::RegEngineReady: engine_ready_q <= cfg_wdata[0];
				ccfr_pkg::RegImageLength: image_length_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			fault_s1 <= s_axis_tuser;
		end
	end

	ccfr_frame_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (v_s1 && advance),
		.rx_byte      (byte_s1),
		.link_fault   (fault_s1),
		.engine_ready (engine_ready_q),
		.image_length (image_length_q),
		.res          (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			verdict_q <= res.verdict;
			code_q    <= res.code;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, code_q, verdict_q};

endmodule

>>> rtl/ccfr_checker.sv
`timescale 1ns / 1ps

module ccfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// accepted verdicts carry no error code
	a_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] != ccfr_pkg::VERDICT_ERROR)
		|-> (m_axis_tdata[4:2] == ccfr_pkg::ERR_NONE) && (m_axis_tdata[1:0] != 2'd3))
		else $error("accepted verdict with error code");

	// an error verdict always names its cause
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] == ccfr_pkg::VERDICT_ERROR)
		|-> (m_axis_tdata[4:2] != ccfr_pkg::ERR_NONE) && (m_axis_tdata[7:5] == 3'd0))
		else $error("error verdict without cause");

	// nothing offered once reset has been seen at an edge
	a_reset: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("result valid during reset");

endmodule

bind crc_checked_frame_receiver_top ccfr_checker u_ccfr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

>>> tb/frame_verdict_checker.sv
`timescale 1ns / 1ps

module frame_verdict_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] link_fault
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [1:0] verdict, [4:2] error_code, [7:5] zero
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	output int          fail_count,
	output int          waiting,
	output int          predicted
);

	import ccfr_pkg::*;

	localparam logic [31:0] MagicWord = 32'h4745_5353;
	localparam int          MaxPrinted = 40;

	typedef struct packed {
		verdict_t  verdict;
		err_code_t code;
	} frame_verdict_t;

	// predicted verdicts, oldest first
	frame_verdict_t verdict_q[$];

	// register copies
	logic        ready_reg;
	logic [31:0] img_len_reg;

	// frame state
	logic [4:0]  hdr_pos;
	logic        sync_bad;
	logic [7:0]  ver_seen;
	logic [7:0]  kind_seen;
	logic [15:0] status_seen;
	logic [31:0] len_seen;
	logic [31:0] crc_seen;
	logic        in_body;
	logic [31:0] body_left;
	logic [31:0] body_crc;

	task automatic report_mismatch(input string msg);
		if (fail_count < MaxPrinted)
			$display("mismatch at %0t ns: %s", $time, msg);
		fail_count++;
	endtask

	function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++)
			r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
		return r;
	endfunction

	task automatic queue_verdict(input verdict_t v, input err_code_t c);
		frame_verdict_t r;
		r.verdict = v;
		r.code = c;
		verdict_q.push_back(r);
		predicted++;
	endtask

	// end of payload: compare the running crc with the header crc
	task automatic finish_body();
		in_body = 1'b0;
		body_left = 32'd0;
		if (~body_crc == crc_seen)
			queue_verdict(VERDICT_IMAGE, ERR_NONE);
		else
			queue_verdict(VERDICT_ERROR, ERR_CRC);
	endtask

	// header complete: magic, version, status, then the message type
	task automatic judge_header();
		hdr_pos = 5'd0;
		if (sync_bad)
			queue_verdict(VERDICT_ERROR, ERR_MAGIC);
		else if (ver_seen != ProtoVersion)
			queue_verdict(VERDICT_ERROR, ERR_VERSION);
		else if (status_seen != 16'd0)
			queue_verdict(VERDICT_ERROR, ERR_MESSAGE);
		else if (kind_seen == TypeHello) begin
			if (len_seen != 32'd0)
				queue_verdict(VERDICT_ERROR, ERR_LENGTH);
			else if (!ready_reg)
				queue_verdict(VERDICT_ERROR, ERR_NOTREADY);
			else
				queue_verdict(VERDICT_HELLO, ERR_NONE);
		end else if (kind_seen == TypeImage) begin
			if (!ready_reg)
				queue_verdict(VERDICT_ERROR, ERR_NOTREADY);
			else if (len_seen != img_len_reg)
				queue_verdict(VERDICT_ERROR, ERR_LENGTH);
			else begin
				body_crc = CrcInit;
				body_left = len_seen;
				if (body_left == 32'd0)
					finish_body();
				else
					in_body = 1'b1;
			end
		end else
			queue_verdict(VERDICT_ERROR, ERR_MESSAGE);
	endtask

	// one accepted word: a link fault, a payload byte or a header byte
	task automatic predict_frame_byte(input logic [7:0] b, input logic fault);
		logic [4:0] pos;
		int         sh;
		if (fault) begin
			hdr_pos = 5'd0;
			sync_bad = 1'b0;
			in_body = 1'b0;
			body_left = 32'd0;
			body_crc = CrcInit;
			queue_verdict(VERDICT_ERROR, ERR_LINK);
		end else if (in_body) begin
			body_crc = crc_next(body_crc, b);
			body_left = body_left - 32'd1;
			if (body_left == 32'd0)
				finish_body();
		end else begin
			pos = (hdr_pos >= 5'(HdrBytes)) ? 5'd0 : hdr_pos;
			if (pos == 5'd0)
				sync_bad = 1'b0;
			if (pos < 5'd4) begin
				sh = int'(pos) * 8;
				if (b != MagicWord[sh +: 8])
					sync_bad = 1'b1;
			end else if (pos == 5'd4)
				ver_seen = b;
			else if (pos == 5'd5)
				kind_seen = b;
			else if (pos < 5'd8) begin
				sh = (int'(pos) - 6) * 8;
				status_seen[sh +: 8] = b;
			end else if (pos < 5'd12) begin
				sh = (int'(pos) - 8) * 8;
				len_seen[sh +: 8] = b;
			end else begin
				sh = (int'(pos) - 12) * 8;
				crc_seen[sh +: 8] = b;
			end
			if (pos == 5'(HdrBytes - 1))
				judge_header();
			else
				hdr_pos = pos + 5'd1;
		end
	endtask

	// watch all three ports at each edge
	always @(posedge clk or negedge arst_n) begin
		frame_verdict_t want;
		if (!arst_n) begin
			ready_reg = 1'b0;
			img_len_reg = 32'd4096;
			hdr_pos = 5'd0;
			sync_bad = 1'b0;
			ver_seen = 8'd0;
			kind_seen = 8'd0;
			status_seen = 16'd0;
			len_seen = 32'd0;
			crc_seen = 32'd0;
			in_body = 1'b0;
			body_left = 32'd0;
			body_crc = CrcInit;
			verdict_q.delete();
			waiting = 0;
		end else begin
			// result word against the oldest prediction
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0)
					report_mismatch($sformatf("result word %h with nothing predicted", m_tdata));
				else begin
					want = verdict_q.pop_front();
					if (m_tdata[1:0] !== want.verdict)
						report_mismatch($sformatf("verdict %0d, predicted %0d",
							m_tdata[1:0], want.verdict));
					if (m_tdata[4:2] !== want.code)
						report_mismatch($sformatf("error code %0d, predicted %0d",
							m_tdata[4:2], want.code));
					if (m_tdata[7:5] !== 3'b000)
						report_mismatch($sformatf("padding bits %b not zero", m_tdata[7:5]));
				end
			end
			// register writes
			if (cfg_we) begin
				if (cfg_index == RegEngineReady)
					ready_reg = cfg_wdata[0];
				else if (cfg_index == RegImageLength)
					img_len_reg = cfg_wdata;
			end
			// received words
			if (s_tvalid && s_tready)
				predict_frame_byte(s_tdata, s_tuser);
			waiting = verdict_q.size();
		end
	end

endmodule

>>> tb/crc_checked_frame_receiver_top_tb.sv
`timescale 1ns / 1ps

module crc_checked_frame_receiver_top_tb;

	import ccfr_pkg::*;

	localparam logic [31:0] MagicWord = 32'h4745_5353;
	localparam int          RandomWords = 850;
	localparam int          RandomVerdicts = 60;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = RegEngineReady;
	logic [31:0] cfg_wdata = 32'd0;

	int          fail_count;
	int          waiting;
	int          predicted;
	int          words_sent = 0;
	bit          burst = 1'b0;
	logic        ready_now = 1'b0;
	logic [31:0] img_len = 32'd4096;

	// clock, 8 ns period
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	crc_checked_frame_receiver_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	frame_verdict_checker verdict_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.s_tuser    (s_axis_tuser),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.waiting    (waiting),
		.predicted  (predicted)
	);

	function automatic int draw_gap();
		return burst ? 0 : int'($urandom_range(0, 8));
	endfunction

	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		repeat (8)
			r = (r >> 1) ^ (r[0] ? CrcPoly : 32'd0);
		return r;
	endfunction

	// result side: random stall before each word
	always begin : result_sink
		int   stall;
		logic took;
		stall = draw_gap();
		repeat (stall) begin
			m_axis_tready <= 1'b0;
			@(posedge clk);
		end
		m_axis_tready <= 1'b1;
		do begin
			@(negedge clk);
			took = m_axis_tvalid;
			@(posedge clk);
		end while (!took);
	end

	// one received word after a random gap
	task automatic send_word(input logic [7:0] b, input logic fault);
		int   gap;
		logic took;
		gap = draw_gap();
		repeat (gap) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= fault;
		do begin
			@(negedge clk);
			took = s_axis_tready;
			@(posedge clk);
		end while (!took);
		words_sent++;
	endtask

	// header bytes up to cut, then a link fault if the header was cut short
	task automatic send_header(input logic [127:0] hdr, input int cut);
		for (int i = 0; i < cut; i++)
			send_word(hdr[i*8 +: 8], 1'b0);
		if (cut < HdrBytes)
			send_word(8'($urandom), 1'b1);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every predicted word has come and the pipeline is empty
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (waiting != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one frame, mostly well formed, with random header faults and aborts
	task automatic send_frame();
		logic [7:0]  kind;
		logic [7:0]  ver;
		logic [15:0] status;
		logic [31:0] magic;
		logic [31:0] len;
		logic [31:0] crc;
		logic [7:0]  body [0:255];
		int          lane;
		int          cut;
		int          n_body;
		int          stop_at;
		int          n_sent;
		bit          clean;

		kind = ($urandom_range(0, 2) == 0) ? TypeHello : TypeImage;
		len = (kind == TypeHello) ? 32'd0 : img_len;
		magic = MagicWord;
		ver = ProtoVersion;
		status = 16'd0;
		crc = $urandom;
		clean = ready_now;

		// header corruptions, possibly several at once
		if ($urandom_range(0, 9) == 0) begin
			lane = $urandom_range(0, 3);
			magic[lane*8 +: 8] = magic[lane*8 +: 8] ^ 8'($urandom_range(1, 255));
			clean = 1'b0;
		end
		if ($urandom_range(0, 9) == 0) begin
			ver = 8'($urandom_range(2, 256));
			clean = 1'b0;
		end
		if ($urandom_range(0, 9) == 0) begin
			status = 16'($urandom_range(1, 65535));
			clean = 1'b0;
		end
		if ($urandom_range(0, 11) == 0) begin
			kind = 8'($urandom_range(3, 256));
			clean = 1'b0;
		end
		if ($urandom_range(0, 7) == 0) begin
			if (kind == TypeHello)
				len = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : 32'($urandom_range(1, 40));
			else if ($urandom_range(0, 1) == 0)
				len = img_len + 32'($urandom_range(1, 64));
			else
				len = $urandom;
			clean = 1'b0;
		end

		// payload plan: full, aborted by a fault, or noise after a rejected header
		n_body = 0;
		stop_at = -1;
		if (clean && kind == TypeImage) begin
			if (len > 32'd256) begin
				n_body = $urandom_range(1, 20);
				stop_at = n_body;
			end else begin
				n_body = int'(len);
				if ($urandom_range(0, 11) == 0)
					stop_at = $urandom_range(0, n_body - 1);
			end
		end else if (!clean && $urandom_range(0, 3) == 0) begin
			n_body = $urandom_range(1, 20);
			stop_at = n_body;
		end
		for (int i = 0; i < n_body; i++)
			body[i] = 8'($urandom);
		if (clean && kind == TypeImage && len <= 32'd256) begin
			crc = CrcInit;
			for (int i = 0; i < n_body; i++)
				crc = crc_step(crc, body[i]);
			crc = ~crc;
			if ($urandom_range(0, 5) == 0)
				crc = crc ^ (32'd1 << $urandom_range(0, 31));
		end

		cut = ($urandom_range(0, 12) == 0) ? int'($urandom_range(0, HdrBytes - 1)) : HdrBytes;
		send_header({crc, len, status, kind, ver, magic}, cut);
		if (cut == HdrBytes) begin
			n_sent = (stop_at < 0) ? n_body : stop_at;
			for (int i = 0; i < n_sent; i++)
				send_word(body[i], 1'b0);
			if (stop_at >= 0)
				send_word(8'($urandom), 1'b1);
		end
	endtask

	// stimulus
	initial begin : stimulus
		int phase;
		int pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fault with no frame open, hello while the engine is not ready, cut header
		send_word(8'hFF, 1'b1);
		send_header({32'h0000_0000, 32'd0, 16'd0, TypeHello, ProtoVersion, MagicWord}, HdrBytes);
		send_header({32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, TypeImage, ProtoVersion, MagicWord},
			5);

		// random phases, each under one register setting
		phase = 0;
		while (words_sent < RandomWords || predicted < RandomVerdicts) begin
			settle();
			ready_now = (phase == 3) ? 1'b0 : ($urandom_range(0, 6) != 0);
			pick = $urandom_range(0, 9);
			if (phase == 1 || pick < 2)
				img_len = 32'd1;
			else if (phase == 2)
				img_len = 32'hFFFF_FFFF;
			else if (pick == 9)
				img_len = 32'($urandom_range(48, 128));
			else
				img_len = 32'($urandom_range(2, 24));
			write_reg(RegEngineReady, {31'd0, ready_now});
			write_reg(RegImageLength, img_len);
			burst = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(5, 10))
				send_frame();
			phase++;
		end

		settle();
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// hard stop
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> filelist.f
rtl/ccfr_pkg.sv
rtl/ccfr_frame_ctrl.sv
rtl/crc_checked_frame_receiver_top.sv
rtl/ccfr_checker.sv
tb/frame_verdict_checker.sv
tb/crc_checked_frame_receiver_top_tb.sv
